FILE: rtl/core/fft_harmonic_amplitudes_core_assert.svh
// Assertion macros for the harmonic amplitude core.
// Included by the top level; needs nothing else.
`ifndef FFT_HARMONIC_AMPLITUDES_CORE_ASSERT_SVH
`define FFT_HARMONIC_AMPLITUDES_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("harmonic amplitude core: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("harmonic amplitude core: next-cycle check failed");

`endif

FILE: rtl/core/fhac_pkg.sv
// Shared types, widths and the twiddle table of the harmonic amplitude core.
// No dependencies.
package fhac_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 24;
  localparam int BASE_W   = 27;
  localparam int IDX_W    = 6;
  localparam int FREQ_W   = 33;
  localparam int AMP_W    = 17;
  localparam int TW_W     = 16;
  localparam int MUL_W    = 25;
  localparam int RAD_W    = 52;
  localparam int ROOT_W   = 26;
  localparam logic [AMP_W-1:0] AMP_MAX = 17'h1FFFF;

  // Complex store word, real part in the low half
  typedef struct packed {
    logic signed [WORD_W-1:0] im;
    logic signed [WORD_W-1:0] re;
  } cword_t;

  // Quarter-wave cosine, Q1.15, 128 steps per turn
  localparam logic signed [TW_W-1:0] QCOS [33] = '{
    16'sd32767, 16'sd32729, 16'sd32610, 16'sd32413, 16'sd32138, 16'sd31786,
    16'sd31357, 16'sd30853, 16'sd30274, 16'sd29622, 16'sd28899, 16'sd28106,
    16'sd27246, 16'sd26320, 16'sd25330, 16'sd24279, 16'sd23170, 16'sd22006,
    16'sd20788, 16'sd19520, 16'sd18205, 16'sd16846, 16'sd15447, 16'sd14010,
    16'sd12540, 16'sd11039, 16'sd9512,  16'sd7962,  16'sd6393,  16'sd4808,
    16'sd3212,  16'sd1608,  16'sd0
  };

  // Cosine part of the twiddle for exponent e (0..63)
  function automatic logic signed [TW_W-1:0] tw_cos(input logic [5:0] e);
    logic [5:0] k;
    k = 6'd0 - e;
    if (e <= 6'd32) return QCOS[e];
    return -QCOS[k];
  endfunction

  // Sine part of the twiddle for exponent e (0..63)
  function automatic logic signed [TW_W-1:0] tw_sin(input logic [5:0] e);
    logic [5:0] k;
    k = (e <= 6'd32) ? (6'd32 - e) : (e - 6'd32);
    return QCOS[k];
  endfunction

endpackage

FILE: rtl/core/fhac_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module fhac_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/core/fft_harmonic_amplitudes_core.sv
// Harmonic amplitude spectrum core: frame load, in-place radix-2 FFT, magnitudes.
// Depends on fhac_pkg, fhac_ram and fft_harmonic_amplitudes_core_assert.svh.
//
// Usage:
//   Samples arrive on the s_ stream (s_tdata[15:0], signed). s_tready is high
//   only while a frame is being loaded; samples are taken back to back.
//   After the POINTS-th sample the core runs the FFT on one shared multiplier:
//   per butterfly the pair is read and the sum written back; with twiddle
//   exponent 0 the difference follows as it is, else after four products. There
//   are (POINTS/2)*log2(POINTS) butterflies, paced by the butterfly sequencer
//   and the single RAM write port. Then POINTS/2 results leave on the m_ stream,
//   bin 0 first, m_tlast on the final bin. Each bin is read, squared twice,
//   summed, put through 26 square-root steps and loaded into the output, then
//   offered until m_tready; a stalled receiver simply holds the core with the
//   result on m_tdata.
//   cfg_we writes base_frequency; write it only while the core is loading.
//   Reset (rst, synchronous) empties the frame, drops any result and sets
//   base_frequency to 1. The sample RAM needs no clearing.
`include "fft_harmonic_amplitudes_core_assert.svh"

module fft_harmonic_amplitudes_core
  import fhac_pkg::*;
#(
  parameter int POINTS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BASE_W-1:0]   cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [15:0] sample
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,   // [5:0] harmonic_index, [38:6] harmonic_frequency,
                                         // [55:39] amplitude
  output logic                m_tlast
);

  localparam int AW       = $clog2(POINTS);
  localparam int HW       = AW - 1;
  localparam int SW       = (AW > 1) ? $clog2(AW) : 1;
  localparam int TW_SHIFT = 7 - AW;

  typedef enum logic [3:0] {
    S_LOAD, S_RD, S_BF, S_WD, S_T1, S_T2, S_T3, S_T4, S_T5,
    S_ORD, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_OUT, S_WAIT
  } state_t;

  state_t                    state;
  logic [AW-1:0]             load_cnt;
  logic [SW-1:0]             stage;
  logic [HW-1:0]             bfly;
  logic [HW-1:0]             bin;
  logic [BASE_W-1:0]         base_freq;
  logic [FREQ_W-1:0]         freq;
  logic signed [MUL_W-1:0]   dr, di, xim;
  logic signed [2*MUL_W-1:0] prod, acc;
  logic signed [WORD_W-1:0]  res_re;
  logic [RAD_W-1:0]          rad, root, bitv;
  logic [4:0]                sq_cnt;
  logic [IDX_W-1:0]          out_idx;
  logic [FREQ_W-1:0]         out_freq;
  logic [AMP_W-1:0]          out_amp;
  logic                      out_last;

  // Butterfly addressing
  logic [AW-1:0] hmask, jx, lo, addr_a, addr_b, rev_addr;
  logic [6:0]    e7;
  logic [5:0]    tw_e;

  // RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr0;
  cword_t        ram_wdata, rd0, rd1;

  // Arithmetic
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [2*MUL_W-1:0] mul;
  logic signed [2*MUL_W:0]   tw_sum;
  logic signed [2*MUL_W:0]   tw_rnd;
  logic [2*MUL_W-1:0]        sq_sum;
  logic [RAD_W-1:0]          trial;
  logic [ROOT_W:0]           amp_full;

  // Reverse the bin number into a store address
  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int k = 0; k < AW; k++) r[k] = v[AW-1-k];
    return r;
  endfunction

  // Pair addresses and twiddle exponent for this butterfly
  always_comb begin
    hmask    = AW'(POINTS / 2 - 1) >> stage;
    jx       = {1'b0, bfly};
    lo       = jx & hmask;
    addr_a   = ((jx & ~hmask) << 1) | lo;
    addr_b   = addr_a | (hmask + AW'(1));
    e7       = 7'(lo) << (7'(stage) + 7'(TW_SHIFT));
    tw_e     = e7[5:0];
    rev_addr = bit_rev({1'b0, bin});
  end

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_T1:    begin op_a = dr;       op_b = MUL_W'(tw_cos(tw_e)); end
      S_T2:    begin op_a = di;       op_b = MUL_W'(tw_sin(tw_e)); end
      S_T3:    begin op_a = di;       op_b = MUL_W'(tw_cos(tw_e)); end
      S_T4:    begin op_a = dr;       op_b = MUL_W'(tw_sin(tw_e)); end
      S_SQ1:   begin op_a = MUL_W'(rd0.re); op_b = MUL_W'(rd0.re); end
      S_SQ2:   begin op_a = xim;      op_b = xim;                  end
      default: begin op_a = '0;       op_b = '0;                   end
    endcase
    mul = op_a * op_b;
  end

  // Round-half-up sums for the twiddle product and magnitude pieces
  always_comb begin
    tw_sum   = (state == S_T3) ? ((2*MUL_W+1)'(acc) + (2*MUL_W+1)'(prod))
                               : ((2*MUL_W+1)'(acc) - (2*MUL_W+1)'(prod));
    tw_rnd   = (tw_sum + (2*MUL_W+1)'(16384)) >>> 15;
    sq_sum   = acc + prod;
    trial    = root + bitv;
    amp_full = (ROOT_W+1)'(root[ROOT_W-1:0]) + (ROOT_W+1)'(POINTS);
    amp_full = amp_full >> (AW + 1);
  end

  // RAM write port select
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = addr_b;
    ram_wdata  = '0;
    ram_raddr0 = (state == S_ORD) ? rev_addr : addr_a;
    case (state)
      S_LOAD: begin
        ram_we       = s_tvalid;
        ram_waddr    = load_cnt;
        ram_wdata.re = WORD_W'(signed'(s_tdata));
      end
      S_BF: begin
        ram_we       = 1'b1;
        ram_waddr    = addr_a;
        ram_wdata.re = WORD_W'(MUL_W'(rd0.re) + MUL_W'(rd1.re));
        ram_wdata.im = WORD_W'(MUL_W'(rd0.im) + MUL_W'(rd1.im));
      end
      S_WD: begin
        ram_we       = 1'b1;
        ram_wdata.re = WORD_W'(dr);
        ram_wdata.im = WORD_W'(di);
      end
      S_T5: begin
        ram_we       = 1'b1;
        ram_wdata.re = res_re;
        ram_wdata.im = WORD_W'(tw_rnd);
      end
      default: ;
    endcase
  end

  fhac_ram #(
    .WIDTH($bits(cword_t)),
    .DEPTH(POINTS)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (addr_b),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      load_cnt  <= '0;
      base_freq <= BASE_W'(1);
      m_tvalid  <= 1'b0;
      stage     <= '0;
      bfly      <= '0;
      bin       <= '0;
      sq_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        base_freq <= cfg_wdata;
      end
      case (state)
        // Collect one frame
        S_LOAD: begin
          if (s_tvalid) begin
            if (load_cnt == AW'(POINTS - 1)) begin
              load_cnt <= '0;
              stage    <= '0;
              bfly     <= '0;
              state    <= S_RD;
            end else begin
              load_cnt <= load_cnt + AW'(1);
            end
          end
        end
        S_RD: state <= S_BF;
        // Sum goes back at once; the difference waits for the twiddle, or goes back as it is with exponent 0
        S_BF: begin
          dr    <= MUL_W'(rd0.re) - MUL_W'(rd1.re);
          di    <= MUL_W'(rd0.im) - MUL_W'(rd1.im);
          state <= (tw_e == 6'd0) ? S_WD : S_T1;
        end
        S_T1: begin prod <= mul; state <= S_T2; end
        S_T2: begin acc <= prod; prod <= mul; state <= S_T3; end
        S_T3: begin res_re <= WORD_W'(tw_rnd); prod <= mul; state <= S_T4; end
        S_T4: begin acc <= prod; prod <= mul; state <= S_T5; end
        // Advance to the next butterfly, stage or the output pass
        S_WD, S_T5: begin
          if (bfly == '1) begin
            bfly <= '0;
            if (stage == SW'(AW - 1)) begin
              bin   <= '0;
              freq  <= '0;
              state <= S_ORD;
            end else begin
              stage <= stage + SW'(1);
              state <= S_RD;
            end
          end else begin
            bfly  <= bfly + HW'(1);
            state <= S_RD;
          end
        end
        S_ORD: state <= S_SQ1;
        S_SQ1: begin prod <= mul; xim <= MUL_W'(rd0.im); state <= S_SQ2; end
        S_SQ2: begin acc <= prod; prod <= mul; state <= S_SQ3; end
        S_SQ3: begin
          rad    <= (bin == '0) ? (RAD_W'(sq_sum[47:0]) << 2)
                                : (RAD_W'(sq_sum[47:0]) << 4);
          root   <= '0;
          bitv   <= RAD_W'(1) << (RAD_W - 2);
          sq_cnt <= '0;
          state  <= S_SQRT;
        end
        // One root digit per cycle
        S_SQRT: begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv   <= bitv >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'(ROOT_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          out_idx  <= IDX_W'(bin);
          out_freq <= freq;
          out_amp  <= (amp_full > (ROOT_W+1)'(AMP_MAX)) ? AMP_MAX : AMP_W'(amp_full);
          out_last <= (bin == '1);
          m_tvalid <= 1'b1;
          state    <= S_WAIT;
        end
        // Hold the result until taken
        S_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (bin == '1) begin
              state <= S_LOAD;
            end else begin
              bin   <= bin + HW'(1);
              freq  <= freq + FREQ_W'(base_freq);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign s_tready = (state == S_LOAD);
  assign m_tdata  = {out_amp, out_freq, out_idx};
  assign m_tlast  = out_last;

  `FHA_ASSERT_NOW(a_one_side, clk, rst, s_tready, !m_tvalid)
  `FHA_ASSERT_NOW(a_last_bin, clk, rst, m_tvalid && m_tlast, out_idx == IDX_W'(POINTS / 2 - 1))
  `FHA_ASSERT_NEXT(a_reload, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)
  `FHA_ASSERT_NEXT(a_first_bin, clk, rst, s_tready && s_tvalid && load_cnt == AW'(POINTS - 1),
                   state == S_RD && stage == '0 && bfly == '0)

endmodule

FILE: dv/testbench.sv
// Self-checking bench for fft_harmonic_amplitudes_core: frames of samples in,
// predicted bin amplitudes and frequencies compared with the m_ stream.
// Depends on fhac_pkg and the core RTL.
module testbench;
  import fhac_pkg::*;

  localparam int NPTS  = 128;
  localparam int NBINS = NPTS / 2;
  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;
    logic              last;
  } bin_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [55:0]       m_tdata;
  logic              m_tlast;

  fft_harmonic_amplitudes_core #(.POINTS(NPTS)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  longint     frame_re [NPTS];
  longint     frame_im [NPTS];
  int         fill_cnt;
  longint     base_hz = 1;
  bin_t       bins_due [$];
  int         errors, n_bins, n_samples, n_frames;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  bit         hold_done;
  int         hold_cycles;
  longint     cycles = 0;

  // Q1.15 product rescale, round half up
  function automatic longint rescale(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Run the transform on the frame and queue the bins it yields
  task automatic predict_spectrum();
    int n, hlf, l, a, e, b, c, s;
    longint xr, xi, yr, yi, dr, di, t;
    longint unsigned mag, rt, amp;
    bin_t r;
    for (n = NPTS; n > 1; n >>= 1) begin
      hlf = n >> 1;
      for (l = 0; l < hlf; l++) begin
        e = (l * (128 / n)) & 63;
        if (e <= 32) begin
          c = QCOS[e];
          s = QCOS[32 - e];
        end else begin
          c = -QCOS[64 - e];
          s = QCOS[e - 32];
        end
        for (a = l; a + hlf < NPTS; a += n) begin
          xr = frame_re[a]; xi = frame_im[a];
          yr = frame_re[a + hlf]; yi = frame_im[a + hlf];
          dr = xr - yr; di = xi - yi;
          frame_re[a] = xr + yr;
          frame_im[a] = xi + yi;
          if (e == 0) begin
            frame_re[a + hlf] = dr;
            frame_im[a + hlf] = di;
          end else begin
            frame_re[a + hlf] = rescale(dr * c + di * s);
            frame_im[a + hlf] = rescale(di * c - dr * s);
          end
        end
      end
    end
    // Bit-reverse reorder
    for (a = 0; a < NPTS; a++) begin
      b = 0;
      for (int k = 0; k < 7; k++) b |= ((a >> k) & 1) << (6 - k);
      if (b > a) begin
        t = frame_re[a]; frame_re[a] = frame_re[b]; frame_re[b] = t;
        t = frame_im[a]; frame_im[a] = frame_im[b]; frame_im[b] = t;
      end
    end
    for (int i = 0; i < NBINS; i++) begin
      mag = frame_re[i] * frame_re[i] + frame_im[i] * frame_im[i];
      rt = int_sqrt(mag * ((i == 0) ? 4 : 16));
      amp = (rt + NPTS) / (2 * NPTS);
      if (amp > 131071) amp = 131071;
      r.idx  = i[IDX_W-1:0];
      r.freq = FREQ_W'(base_hz * i);
      r.amp  = amp[AMP_W-1:0];
      r.last = (i == NBINS - 1);
      bins_due = {bins_due, r};
    end
  endtask

  // Offer one sample and hold it until the core takes it
  task automatic send_sample(logic signed [15:0] v);
    while (idle_on && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    n_samples++;
    frame_re[fill_cnt] = v;
    frame_im[fill_cnt] = 0;
    fill_cnt++;
    if (fill_cnt == NPTS) begin
      fill_cnt = 0;
      n_frames++;
      predict_spectrum();
    end
  endtask

  // Wait for every bin, then write the register while the core is loading
  task automatic set_base(logic [BASE_W-1:0] hz);
    s_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_hz = hz;
  endtask

  task automatic test_extremes();
    set_base(27'h7FFFFFF);
    // Full-scale square wave, then a constant negative extreme
    for (int i = 0; i < 32; i++) send_sample((i & 1) ? 16'sh8000 : 16'sh7FFF);
    for (int i = 0; i < 16; i++) send_sample(16'sh8000);
  endtask

  task automatic test_tone();
    for (int i = 0; i < 48; i++)
      send_sample(16'(int'(20000.0 * $cos(2.0 * 3.14159265358979 * 5 * i / NPTS))));
  endtask

  // Close the frame with no idling on either side
  task automatic test_random_burst();
    idle_on = 1'b0;
    for (int i = 0; i < 32; i++) send_sample(16'($urandom()));
    idle_on = 1'b1;
  endtask

  // Receiver holds off while samples of the next frame are offered
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 56; i++) send_sample(16'($urandom_range(0, 2000) - 1000));
  endtask

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_cycles <= 6000;
      m_tready    <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 24);
    end
  end

  // Compare each bin with the oldest prediction
  always @(posedge clk) begin
    bin_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.idx  = m_tdata[5:0];
      got.freq = m_tdata[38:6];
      got.amp  = m_tdata[55:39];
      got.last = m_tlast;
      n_bins++;
      if (bins_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected bin %0d amp %0d", got.idx, got.amp);
      end else begin
        want = bins_due.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("bin mismatch: exp idx %0d freq %0d amp %0d last %0b, got %0d %0d %0d %0b",
                     want.idx, want.freq, want.amp, want.last,
                     got.idx, got.freq, got.amp, got.last);
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d bins outstanding", bins_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_tone();
    test_random_burst();
    test_backpressure();
    s_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d samples in %0d frames, %0d bins checked, %0d errors",
             n_samples, n_frames, n_bins, errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
